/* src/small_yaw_rate_pulse_shaper_macros.svh */
// assertion macros for the yaw rate pulse shaper
// used by the top level only, no other dependencies
`ifndef SMALL_YAW_RATE_PULSE_SHAPER_MACROS_SVH
`define SMALL_YAW_RATE_PULSE_SHAPER_MACROS_SVH

// same-cycle implication, masked during reset
`define SYRPS_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define SYRPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/syrps_pkg.sv */
// shared widths, codes and structs for the yaw rate pulse shaper
// no dependencies; used by every module of the block
package syrps_pkg;

  localparam int RATE_WIDTH     = 16;
  localparam int TICK_WIDTH     = 8;
  localparam int MAG_WIDTH      = RATE_WIDTH - 1;
  localparam int THRESH_WIDTH   = MAG_WIDTH + TICK_WIDTH;
  localparam int CREDIT_WIDTH   = MAG_WIDTH + TICK_WIDTH + 2;
  localparam int CFG_DATA_WIDTH = RATE_WIDTH;

  localparam logic [MAG_WIDTH-1:0]    MIN_RATE_RESET    = MAG_WIDTH'(1638);
  localparam logic [TICK_WIDTH-1:0]   PULSE_TICKS_RESET = TICK_WIDTH'(1);
  localparam logic [THRESH_WIDTH-1:0] THRESH_RESET      =
    THRESH_WIDTH'(1638 * 1);

  // configuration register indexes
  typedef enum logic {
    REG_MIN_RATE    = 1'b0,
    REG_PULSE_TICKS = 1'b1
  } cfg_reg_t;

  // pulse direction codes
  typedef enum logic [1:0] {
    SIGN_NONE = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd3
  } pulse_sign_t;

  // configuration as seen by the datapath
  typedef struct packed {
    logic                    clear;
    logic [MAG_WIDTH-1:0]    min_rate;
    logic [TICK_WIDTH-1:0]   ticks;
    logic [THRESH_WIDTH-1:0] threshold;
  } cfg_t;

  // shaper state summary
  typedef struct packed {
    logic        pulse_active;
    pulse_sign_t sign;
  } shaper_stat_t;

endpackage

/* src/syrps_cfg.sv */
// configuration registers and precomputed pulse threshold
// depends on syrps_pkg
module syrps_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic                                cfg_index,
  input  logic [syrps_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata,
  output syrps_pkg::cfg_t                     cfg_o
);

  logic [syrps_pkg::MAG_WIDTH-1:0]    min_rate_r, min_rate_nxt;
  logic [syrps_pkg::TICK_WIDTH-1:0]   ticks_r, ticks_nxt;
  logic [syrps_pkg::THRESH_WIDTH-1:0] threshold_r, threshold_nxt;

  // register writes; a zero pulse length counts as one tick
  always_comb begin
    min_rate_nxt = min_rate_r;
    ticks_nxt    = ticks_r;
    if (cfg_valid) begin
      unique case (syrps_pkg::cfg_reg_t'(cfg_index))
        syrps_pkg::REG_MIN_RATE: begin
          min_rate_nxt = cfg_wdata[syrps_pkg::MAG_WIDTH-1:0];
        end
        syrps_pkg::REG_PULSE_TICKS: begin
          ticks_nxt = (cfg_wdata[syrps_pkg::TICK_WIDTH-1:0] == '0) ?
                      syrps_pkg::TICK_WIDTH'(1) : cfg_wdata[syrps_pkg::TICK_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
    // threshold follows the new values so it is ready with them
    threshold_nxt = syrps_pkg::THRESH_WIDTH'(min_rate_nxt) *
                    syrps_pkg::THRESH_WIDTH'(ticks_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_rate_r  <= syrps_pkg::MIN_RATE_RESET;
      ticks_r     <= syrps_pkg::PULSE_TICKS_RESET;
      threshold_r <= syrps_pkg::THRESH_RESET;
    end else begin
      min_rate_r  <= min_rate_nxt;
      ticks_r     <= ticks_nxt;
      threshold_r <= threshold_nxt;
    end
  end

  // any write clears the shaper state
  assign cfg_o.clear     = cfg_valid;
  assign cfg_o.min_rate  = min_rate_r;
  assign cfg_o.ticks     = ticks_r;
  assign cfg_o.threshold = threshold_r;

endmodule

/* src/syrps_shaper.sv */
// shaping datapath: credit, direction and pulse counter with the per-item update
// depends on syrps_pkg
module syrps_shaper (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  syrps_pkg::cfg_t                       cfg_i,
  input  logic                                  item_go,
  input  logic signed [syrps_pkg::RATE_WIDTH-1:0] yaw_request,
  input  logic                                  correction_on,
  output logic signed [syrps_pkg::RATE_WIDTH-1:0] yaw_command,
  output logic                                  pulsing,
  output syrps_pkg::shaper_stat_t               stat_o
);

  localparam int CW = syrps_pkg::CREDIT_WIDTH;
  localparam int RW = syrps_pkg::RATE_WIDTH;
  localparam int TW = syrps_pkg::TICK_WIDTH;

  logic [CW-1:0]          credit_r, credit_nxt;
  syrps_pkg::pulse_sign_t sign_r, sign_nxt;
  logic [TW-1:0]          ticks_left_r, ticks_left_nxt;

  logic [RW-1:0]          raw, mag, cmd, pulse_cmd;
  logic                   neg, inactive, pass, reached;
  syrps_pkg::pulse_sign_t dir;
  logic [CW-1:0]          credit_base, credit_acc;
  logic [TW-1:0]          ticks_base;
  logic [CW:0]            sum, diff;

  // magnitude and class of the request
  always_comb begin
    raw      = yaw_request;
    neg      = raw[RW-1];
    mag      = neg ? (~raw + RW'(1)) : raw;
    inactive = (cfg_i.min_rate == '0) || !correction_on || (raw == '0);
    pass     = mag >= RW'(cfg_i.min_rate);
    dir      = neg ? syrps_pkg::SIGN_NEG : syrps_pkg::SIGN_POS;
  end

  // credit accumulate with saturation, threshold test by borrow
  always_comb begin
    credit_base = (sign_r == dir) ? credit_r : '0;
    ticks_base  = (sign_r == dir) ? ticks_left_r : '0;
    sum         = (CW+1)'(credit_base) + (CW+1)'(mag);
    credit_acc  = sum[CW] ? '1 : sum[CW-1:0];
    diff        = {1'b0, credit_acc} - (CW+1)'(cfg_i.threshold);
    reached     = !diff[CW];
    pulse_cmd   = neg ? (RW'(0) - RW'(cfg_i.min_rate)) : RW'(cfg_i.min_rate);
  end

  // next state and result
  always_comb begin
    credit_nxt     = credit_r;
    sign_nxt       = sign_r;
    ticks_left_nxt = ticks_left_r;
    cmd            = '0;
    pulsing        = 1'b0;
    priority if (inactive) begin
      credit_nxt     = '0;
      sign_nxt       = syrps_pkg::SIGN_NONE;
      ticks_left_nxt = '0;
    end else if (pass) begin
      credit_nxt     = '0;
      sign_nxt       = syrps_pkg::SIGN_NONE;
      ticks_left_nxt = '0;
      cmd            = raw;
    end else begin
      sign_nxt       = dir;
      credit_nxt     = credit_acc;
      ticks_left_nxt = ticks_base;
      if (ticks_base != '0) begin
        // pulse in progress
        ticks_left_nxt = ticks_base - TW'(1);
        cmd            = pulse_cmd;
        pulsing        = 1'b1;
      end else if (reached) begin
        // enough credit: start a new pulse
        credit_nxt     = diff[CW-1:0];
        ticks_left_nxt = cfg_i.ticks - TW'(1);
        cmd            = pulse_cmd;
        pulsing        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_i.clear) begin
      credit_r     <= '0;
      sign_r       <= syrps_pkg::SIGN_NONE;
      ticks_left_r <= '0;
    end else if (item_go) begin
      credit_r     <= credit_nxt;
      sign_r       <= sign_nxt;
      ticks_left_r <= ticks_left_nxt;
    end
  end

  assign yaw_command         = $signed(cmd);
  assign stat_o.pulse_active = (ticks_left_r != '0);
  assign stat_o.sign         = sign_r;

endmodule

/* src/small_yaw_rate_pulse_shaper.sv */
// top level of the yaw rate pulse shaper: input register, shaper, result register
// depends on syrps_pkg, syrps_cfg, syrps_shaper and the assertion macro header
//
//  channel | ports                                      | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid/in_ready, in_yaw_request,         | in
//          | in_correction_on                           |
//  out     | out_valid/out_ready, out_yaw_command,      | out
//          | out_pulsing                                |
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_wdata  | in
//
// one item per cycle sustained while out_ready is not held low; an accepted item passes through
// the input register, then the result register, with one pass of shaper logic between them
// synchronous active-low reset loads the register reset values and clears the state
// a stalled output holds its result while one more item waits in the input register
// cfg_ready is always high; a write clears credit, direction and pulse count
`include "small_yaw_rate_pulse_shaper_macros.svh"

module small_yaw_rate_pulse_shaper (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [syrps_pkg::RATE_WIDTH-1:0] in_yaw_request,
  input  logic                                   in_correction_on,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [syrps_pkg::RATE_WIDTH-1:0] out_yaw_command,
  output logic                                   out_pulsing,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic                                   cfg_index,
  input  logic [syrps_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata
);

  syrps_pkg::cfg_t         cfg;
  syrps_pkg::shaper_stat_t stat;

  logic                                   s1_valid_r, s1_valid_nxt;
  logic signed [syrps_pkg::RATE_WIDTH-1:0] s1_req_r;
  logic                                   s1_on_r;
  logic                                   s1_adv;
  logic                                   out_valid_r, out_valid_nxt;
  logic signed [syrps_pkg::RATE_WIDTH-1:0] out_cmd_r, res_cmd;
  logic                                   out_pulsing_r, res_pulsing;

  assign cfg_ready = 1'b1;

  syrps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  syrps_shaper u_shaper (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_i         (cfg),
    .item_go       (s1_adv),
    .yaw_request   (s1_req_r),
    .correction_on (s1_on_r),
    .yaw_command   (res_cmd),
    .pulsing       (res_pulsing),
    .stat_o        (stat)
  );

  // pipeline flow control
  always_comb begin
    s1_adv        = s1_valid_r && (!out_valid_r || out_ready);
    in_ready      = !s1_valid_r || s1_adv;
    s1_valid_nxt  = (in_valid && in_ready) || (s1_valid_r && !s1_adv);
    out_valid_nxt = s1_adv || (out_valid_r && !out_ready);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input item register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req_r <= in_yaw_request;
      s1_on_r  <= in_correction_on;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_cmd_r     <= res_cmd;
      out_pulsing_r <= res_pulsing;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_yaw_command = out_cmd_r;
  assign out_pulsing     = out_pulsing_r;

  // checks
  `SYRPS_ASSERT_HOLDS(a_pulse_nonzero, clk, rst_n, out_valid_r && out_pulsing_r, out_cmd_r != '0, "pulse item with zero command")
  `SYRPS_ASSERT_HOLDS(a_pulse_has_dir, clk, rst_n, stat.pulse_active, stat.sign != syrps_pkg::SIGN_NONE, "pulse count without direction")
  `SYRPS_ASSERT_HOLDS(a_stall_only_full, clk, rst_n, !in_ready, out_valid_r && s1_valid_r, "input stalled with room")
  `SYRPS_ASSERT_NEXT(a_adv_fills_out, clk, rst_n, s1_adv, out_valid_r, "advanced item lost")

endmodule
